>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the access-log line parser.
// Each macro checks one clocked implication and is disabled while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/alp_pkg.sv
// Package for the access-log line parser: field widths, character codes,
// parse phases, shared structs and the saturating decimal accumulate steps.
// Used by every module in rtl/core; depends on nothing.
package alp_pkg;

    // Field widths.
    localparam int OFS_W = 12;
    localparam int ST_W  = 32;
    localparam int SZ_W  = 48;
    localparam int DIG_W = 4;

    // Default maximum line length in bytes.
    localparam int LINE_BYTES_DEF = 4096;

    // Characters the parser looks for.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // Saturation limits of the magnitudes and of the positive results.
    localparam logic [ST_W-1:0] STATUS_CAP = 32'h8000_0000;
    localparam logic [ST_W-1:0] STATUS_MAX = 32'h7FFF_FFFF;
    localparam logic [SZ_W-1:0] SIZE_CAP   = 48'h8000_0000_0000;
    localparam logic [SZ_W-1:0] SIZE_MAX   = 48'h7FFF_FFFF_FFFF;

    // Parse phases, in the order the fields appear on a line.
    typedef enum logic [3:0] {
        PH_ADDR    = 4'd0,
        PH_BRACK   = 4'd1,
        PH_TIME    = 4'd2,
        PH_QUOTE1  = 4'd3,
        PH_VERB    = 4'd4,
        PH_TARGET  = 4'd5,
        PH_QUOTE2  = 4'd6,
        PH_ST_WS   = 4'd7,
        PH_ST_SIGN = 4'd8,
        PH_ST_DIG  = 4'd9,
        PH_SZ_SP   = 4'd10,
        PH_SZ_WS   = 4'd11,
        PH_SZ_SIGN = 4'd12,
        PH_SZ_DIG  = 4'd13,
        PH_DONE    = 4'd14,
        PH_ERR     = 4'd15
    } phase_t;

    // One input transfer.
    typedef struct packed {
        logic [7:0] byte_req;
        logic       last;
    } alp_item_t;

    // End-of-line result before sign handling and clamping.
    typedef struct packed {
        logic            bad;
        logic [OFS_W-1:0] addr_len;
        logic [OFS_W-1:0] time_start;
        logic [OFS_W-1:0] time_len;
        logic [OFS_W-1:0] method_start;
        logic [OFS_W-1:0] method_len;
        logic [OFS_W-1:0] path_start;
        logic [OFS_W-1:0] path_len;
        logic [ST_W-1:0]  status_acc;
        logic             status_neg;
        logic [SZ_W-1:0]  size_acc;
        logic             size_neg;
    } alp_raw_t;

    // Handshake status of the input register toward the parse stage.
    typedef struct packed {
        logic valid;
        logic emit;
    } alp_ctl_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c inside {CH_SPACE, [CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_NINE]});
    endfunction

    // acc * 10 + digit, clamped at the status cap; the times ten is 8x + 2x.
    function automatic logic [ST_W-1:0] status_step(input logic [ST_W-1:0] acc,
                                                    input logic [DIG_W-1:0] dig);
        logic [ST_W+3:0] t;
        t = ((ST_W + 4)'(acc) << 3) + ((ST_W + 4)'(acc) << 1) + (ST_W + 4)'(dig);
        return (t > (ST_W + 4)'(STATUS_CAP)) ? STATUS_CAP : t[ST_W-1:0];
    endfunction

    // acc * 10 + digit, clamped at the size cap.
    function automatic logic [SZ_W-1:0] size_step(input logic [SZ_W-1:0] acc,
                                                  input logic [DIG_W-1:0] dig);
        logic [SZ_W+3:0] t;
        t = ((SZ_W + 4)'(acc) << 3) + ((SZ_W + 4)'(acc) << 1) + (SZ_W + 4)'(dig);
        return (t > (SZ_W + 4)'(SIZE_CAP)) ? SIZE_CAP : t[SZ_W-1:0];
    endfunction

endpackage

>>> rtl/core/access_log_line_parser.sv
// Access-log line parser. Bytes of a line arrive one per transfer on the req
// channel; at the last byte, or at a zero byte, one result with the field
// offsets and lengths, the status, the response size and a bad-line flag is
// offered on the rsp channel. The parser takes one byte per clock cycle while
// no ending byte waits for the result register to free; every byte is folded
// into the line state by one combinational update, whose depth is set by the
// size accumulator (a 52-bit times-ten add and saturation compare). A byte is
// registered in the input register on acceptance and processed from there; the
// result of an ending byte is then registered in the result register, which
// offers it on the rsp channel. A waiting result does not block bytes that produce no result.
// Depends on alp_pkg, alp_in_stage, alp_parse, alp_out_stage and assert_macros.svh.
`include "assert_macros.svh"

module access_log_line_parser
#(
    parameter int LINE_BYTES = alp_pkg::LINE_BYTES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [7:0]                      byte_req,
    input  logic                            last,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            bad_line,
    output logic [alp_pkg::OFS_W-1:0]       addr_len,
    output logic [alp_pkg::OFS_W-1:0]       time_start,
    output logic [alp_pkg::OFS_W-1:0]       time_len,
    output logic [alp_pkg::OFS_W-1:0]       method_start,
    output logic [alp_pkg::OFS_W-1:0]       method_len,
    output logic [alp_pkg::OFS_W-1:0]       path_start,
    output logic [alp_pkg::OFS_W-1:0]       path_len,
    output logic signed [alp_pkg::ST_W-1:0] status,
    output logic signed [alp_pkg::SZ_W-1:0] size
);

    alp_pkg::alp_item_t item;
    alp_pkg::alp_raw_t  raw;
    alp_pkg::alp_ctl_t  ctl;
    logic               in_valid;
    logic               emit;
    logic               out_free;
    logic               step;
    logic               load;

    assign ctl.valid = in_valid;
    assign ctl.emit  = emit;

    // A byte moves on when it makes no result or the result register is free.
    assign step = ctl.valid && (!ctl.emit || out_free);
    assign load = step && ctl.emit;

    alp_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .byte_req  (byte_req),
        .last      (last),
        .take      (step),
        .valid     (in_valid),
        .item      (item)
    );

    alp_parse #(
        .LINE_BYTES (LINE_BYTES)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item),
        .emit  (emit),
        .raw   (raw)
    );

    alp_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .raw          (raw),
        .free         (out_free),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .bad_line     (bad_line),
        .addr_len     (addr_len),
        .time_start   (time_start),
        .time_len     (time_len),
        .method_start (method_start),
        .method_len   (method_len),
        .path_start   (path_start),
        .path_len     (path_len),
        .status       (status),
        .size         (size)
    );

    // A result handed to the output register is offered in the next cycle.
    `ASSERT_NEXT_CYCLE(a_load_shows, clk, rst_n, load, rsp_valid)

    // The byte side is held back only while a byte waits in the input register.
    `ASSERT_SAME_CYCLE(a_stall_full, clk, rst_n, req_stall, in_valid)

    // A waiting byte that is not processed stays in the input register.
    `ASSERT_NEXT_CYCLE(a_byte_kept, clk, rst_n, in_valid && !step, in_valid)

    // A bad line carries zero numbers and offsets.
    `ASSERT_SAME_CYCLE(a_bad_zero, clk, rst_n, rsp_valid && bad_line, (status == '0) && (size == '0) && (addr_len == '0) && (path_len == '0))

endmodule

>>> rtl/core/alp_in_stage.sv
// Input register of the access-log line parser.
// Holds one byte transfer until the parse stage takes it; uses alp_pkg.
module alp_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [7:0]         byte_req,
    input  logic               last,
    input  logic               take,
    output logic               valid,
    output alp_pkg::alp_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    alp_pkg::alp_item_t item_reg;

    // The register is refilled when it is empty or is being drained this cycle.
    logic load;
    assign load      = !valid_reg || take;
    assign req_stall = !load;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = req_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        if (load && req_valid)
        begin
            item_reg.byte_req <= byte_req;
            item_reg.last     <= last;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

>>> rtl/core/alp_parse.sv
// Parse stage of the access-log line parser: per-line state and its one-byte update.
// Produces the end-of-line result; uses alp_pkg.
module alp_parse
#(
    parameter int LINE_BYTES = alp_pkg::LINE_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  alp_pkg::alp_item_t item,
    output logic               emit,
    output alp_pkg::alp_raw_t  raw
);

    localparam int POS_W = $clog2(LINE_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_BYTES);
    localparam int OW = alp_pkg::OFS_W;

    // State registers.
    alp_pkg::phase_t         phase_reg, phase_next, phase_upd;
    logic [POS_W-1:0]        pos_reg, pos_next, pos_upd;
    logic [OW-1:0]           addr_len_reg, addr_len_next, addr_len_upd;
    logic [OW-1:0]           stamp_start_reg, stamp_start_next, stamp_start_upd;
    logic [OW-1:0]           stamp_len_reg, stamp_len_next, stamp_len_upd;
    logic [OW-1:0]           verb_start_reg, verb_start_next, verb_start_upd;
    logic [OW-1:0]           verb_len_reg, verb_len_next, verb_len_upd;
    logic [OW-1:0]           target_start_reg, target_start_next, target_start_upd;
    logic [OW-1:0]           target_len_reg, target_len_next, target_len_upd;
    logic [alp_pkg::ST_W-1:0] st_acc_reg, st_acc_next, st_acc_upd;
    logic                    st_neg_reg, st_neg_next, st_neg_upd;
    logic [alp_pkg::SZ_W-1:0] sz_acc_reg, sz_acc_next, sz_acc_upd;
    logic                    sz_neg_reg, sz_neg_next, sz_neg_upd;
    logic                    ended_reg, ended_next;

    // Byte decode.
    logic [7:0]                c;
    logic                      fin;
    logic                      c_ws;
    logic                      c_dig;
    logic                      c_sign;
    logic [alp_pkg::DIG_W-1:0] dval;
    logic [OW-1:0]             p;
    logic [OW-1:0]             p1;
    logic                      run_first;
    logic                      run_gen;

    assign c      = item.byte_req;
    assign fin    = item.last;
    assign c_ws   = alp_pkg::is_ws(c);
    assign c_dig  = alp_pkg::is_digit(c);
    assign c_sign = (c == alp_pkg::CH_PLUS) || (c == alp_pkg::CH_MINUS);
    assign dval   = alp_pkg::DIG_W'(c - alp_pkg::CH_ZERO);
    assign p      = OW'(pos_reg);
    assign p1     = p + OW'(1);

    // A zero byte or the last byte closes a line, unless the rest of a line
    // already closed by a zero byte is being dropped.
    assign emit = !ended_reg && ((c == alp_pkg::CH_NUL) || fin);

    // Effect of the current byte on the line state.
    always_comb
    begin
        phase_upd        = phase_reg;
        pos_upd          = pos_reg;
        addr_len_upd     = addr_len_reg;
        stamp_start_upd  = stamp_start_reg;
        stamp_len_upd    = stamp_len_reg;
        verb_start_upd   = verb_start_reg;
        verb_len_upd     = verb_len_reg;
        target_start_upd = target_start_reg;
        target_len_upd   = target_len_reg;
        st_acc_upd       = st_acc_reg;
        st_neg_upd       = st_neg_reg;
        sz_acc_upd       = sz_acc_reg;
        sz_neg_upd       = sz_neg_reg;
        run_first        = 1'b0;
        run_gen          = 1'b0;
        if (!ended_reg && (c != alp_pkg::CH_NUL) &&
            (phase_reg != alp_pkg::PH_DONE) && (phase_reg != alp_pkg::PH_ERR))
        begin
            if (pos_reg >= POS_LIMIT)
            begin
                phase_upd = alp_pkg::PH_ERR;
            end
            else
            begin
                pos_upd = pos_reg + POS_W'(1);
                case (phase_reg)
                    alp_pkg::PH_ADDR:
                    begin
                        if (c == alp_pkg::CH_SPACE)
                        begin
                            addr_len_upd = p;
                            phase_upd    = alp_pkg::PH_BRACK;
                        end
                    end
                    alp_pkg::PH_BRACK:
                    begin
                        if (c == alp_pkg::CH_LBRACK)
                        begin
                            stamp_start_upd = p1;
                            phase_upd       = alp_pkg::PH_TIME;
                        end
                    end
                    alp_pkg::PH_TIME:
                    begin
                        if (c == alp_pkg::CH_RBRACK)
                        begin
                            stamp_len_upd = p - stamp_start_reg;
                            phase_upd     = alp_pkg::PH_QUOTE1;
                        end
                    end
                    alp_pkg::PH_QUOTE1:
                    begin
                        if (c == alp_pkg::CH_QUOTE)
                        begin
                            verb_start_upd = p1;
                            phase_upd      = alp_pkg::PH_VERB;
                        end
                    end
                    alp_pkg::PH_VERB:
                    begin
                        if (c == alp_pkg::CH_SPACE)
                        begin
                            verb_len_upd     = p - verb_start_reg;
                            target_start_upd = p1;
                            phase_upd        = alp_pkg::PH_TARGET;
                        end
                    end
                    alp_pkg::PH_TARGET:
                    begin
                        if (c == alp_pkg::CH_SPACE)
                        begin
                            target_len_upd = p - target_start_reg;
                            phase_upd      = alp_pkg::PH_QUOTE2;
                        end
                    end
                    alp_pkg::PH_QUOTE2:
                    begin
                        if (c == alp_pkg::CH_QUOTE)
                        begin
                            phase_upd = alp_pkg::PH_ST_WS;
                        end
                    end
                    alp_pkg::PH_ST_WS:
                    begin
                        if (c_ws)
                        begin
                            phase_upd = alp_pkg::PH_ST_WS;
                        end
                        else if (c_sign)
                        begin
                            st_neg_upd = (c == alp_pkg::CH_MINUS);
                            phase_upd  = alp_pkg::PH_ST_SIGN;
                        end
                        else if (c_dig)
                        begin
                            st_acc_upd = alp_pkg::status_step('0, dval);
                            phase_upd  = alp_pkg::PH_ST_DIG;
                        end
                        else
                        begin
                            phase_upd = alp_pkg::PH_ERR;
                        end
                    end
                    alp_pkg::PH_ST_SIGN:
                    begin
                        if (c_dig)
                        begin
                            st_acc_upd = alp_pkg::status_step(st_acc_reg, dval);
                            phase_upd  = alp_pkg::PH_ST_DIG;
                        end
                        else
                        begin
                            phase_upd = alp_pkg::PH_ERR;
                        end
                    end
                    alp_pkg::PH_ST_DIG:
                    begin
                        if (c_dig)
                        begin
                            st_acc_upd = alp_pkg::status_step(st_acc_reg, dval);
                        end
                        else
                        begin
                            run_first = 1'b1;
                        end
                    end
                    alp_pkg::PH_SZ_SP:
                    begin
                        run_first = 1'b1;
                    end
                    alp_pkg::PH_SZ_WS:
                    begin
                        run_gen = 1'b1;
                    end
                    alp_pkg::PH_SZ_SIGN:
                    begin
                        if (c_dig)
                        begin
                            sz_acc_upd = alp_pkg::size_step(sz_acc_reg, dval);
                            phase_upd  = alp_pkg::PH_SZ_DIG;
                        end
                        else
                        begin
                            sz_acc_upd = '0;
                            phase_upd  = alp_pkg::PH_DONE;
                        end
                    end
                    alp_pkg::PH_SZ_DIG:
                    begin
                        if (c_dig)
                        begin
                            sz_acc_upd = alp_pkg::size_step(sz_acc_reg, dval);
                        end
                        else
                        begin
                            phase_upd = alp_pkg::PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_upd = phase_reg;
                    end
                endcase

                // First byte after the status digits, or after a space there: a space or a dash is special.
                if (run_first)
                begin
                    if (c == alp_pkg::CH_SPACE)
                    begin
                        phase_upd = alp_pkg::PH_SZ_SP;
                    end
                    else if (c == alp_pkg::CH_MINUS)
                    begin
                        phase_upd = alp_pkg::PH_DONE;
                    end
                    else
                    begin
                        run_gen = 1'b1;
                    end
                end

                // General start of the size: whitespace, sign, digit or end.
                if (run_gen)
                begin
                    if (c_ws)
                    begin
                        phase_upd = alp_pkg::PH_SZ_WS;
                    end
                    else if (c_sign)
                    begin
                        sz_neg_upd = (c == alp_pkg::CH_MINUS);
                        phase_upd  = alp_pkg::PH_SZ_SIGN;
                    end
                    else if (c_dig)
                    begin
                        sz_acc_upd = alp_pkg::size_step('0, dval);
                        phase_upd  = alp_pkg::PH_SZ_DIG;
                    end
                    else
                    begin
                        phase_upd = alp_pkg::PH_DONE;
                    end
                end
            end
        end
    end

    // Next state: the updated line, or a fresh line once a result goes out.
    always_comb
    begin
        phase_next        = phase_upd;
        pos_next          = pos_upd;
        addr_len_next     = addr_len_upd;
        stamp_start_next  = stamp_start_upd;
        stamp_len_next    = stamp_len_upd;
        verb_start_next   = verb_start_upd;
        verb_len_next     = verb_len_upd;
        target_start_next = target_start_upd;
        target_len_next   = target_len_upd;
        st_acc_next       = st_acc_upd;
        st_neg_next       = st_neg_upd;
        sz_acc_next       = sz_acc_upd;
        sz_neg_next       = sz_neg_upd;
        ended_next        = ended_reg;
        if (ended_reg)
        begin
            ended_next = !fin;
        end
        else if (emit)
        begin
            phase_next        = alp_pkg::PH_ADDR;
            pos_next          = '0;
            addr_len_next     = '0;
            stamp_start_next  = '0;
            stamp_len_next    = '0;
            verb_start_next   = '0;
            verb_len_next     = '0;
            target_start_next = '0;
            target_len_next   = '0;
            st_acc_next       = '0;
            st_neg_next       = 1'b0;
            sz_acc_next       = '0;
            sz_neg_next       = 1'b0;
            ended_next        = !fin;
        end
    end

    // Result of the line as it stands after the current byte.
    always_comb
    begin
        raw.bad          = (phase_upd < alp_pkg::PH_ST_DIG) || (phase_upd == alp_pkg::PH_ERR);
        raw.addr_len     = addr_len_upd;
        raw.time_start   = stamp_start_upd;
        raw.time_len     = stamp_len_upd;
        raw.method_start = verb_start_upd;
        raw.method_len   = verb_len_upd;
        raw.path_start   = target_start_upd;
        raw.path_len     = target_len_upd;
        raw.status_acc   = st_acc_upd;
        raw.status_neg   = st_neg_upd;
        raw.size_acc     = sz_acc_upd;
        raw.size_neg     = sz_neg_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= alp_pkg::PH_ADDR;
            pos_reg          <= '0;
            addr_len_reg     <= '0;
            stamp_start_reg  <= '0;
            stamp_len_reg    <= '0;
            verb_start_reg   <= '0;
            verb_len_reg     <= '0;
            target_start_reg <= '0;
            target_len_reg   <= '0;
            st_acc_reg       <= '0;
            st_neg_reg       <= 1'b0;
            sz_acc_reg       <= '0;
            sz_neg_reg       <= 1'b0;
            ended_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            addr_len_reg     <= addr_len_next;
            stamp_start_reg  <= stamp_start_next;
            stamp_len_reg    <= stamp_len_next;
            verb_start_reg   <= verb_start_next;
            verb_len_reg     <= verb_len_next;
            target_start_reg <= target_start_next;
            target_len_reg   <= target_len_next;
            st_acc_reg       <= st_acc_next;
            st_neg_reg       <= st_neg_next;
            sz_acc_reg       <= sz_acc_next;
            sz_neg_reg       <= sz_neg_next;
            ended_reg        <= ended_next;
        end
    end

endmodule

>>> rtl/core/alp_out_stage.sv
// Result register of the access-log line parser, with sign handling and clamping
// of the two numbers on the way to the ports; uses alp_pkg.
module alp_out_stage
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  alp_pkg::alp_raw_t               raw,
    output logic                            free,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            bad_line,
    output logic [alp_pkg::OFS_W-1:0]       addr_len,
    output logic [alp_pkg::OFS_W-1:0]       time_start,
    output logic [alp_pkg::OFS_W-1:0]       time_len,
    output logic [alp_pkg::OFS_W-1:0]       method_start,
    output logic [alp_pkg::OFS_W-1:0]       method_len,
    output logic [alp_pkg::OFS_W-1:0]       path_start,
    output logic [alp_pkg::OFS_W-1:0]       path_len,
    output logic signed [alp_pkg::ST_W-1:0] status,
    output logic signed [alp_pkg::SZ_W-1:0] size
);

    logic              valid_reg;
    logic              valid_next;
    alp_pkg::alp_raw_t raw_reg;
    logic              ok;

    // The register can take a new result once the held one is transferred.
    assign free = !valid_reg || !rsp_stall;

    always_comb
    begin
        valid_next = valid_reg && rsp_stall;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            raw_reg <= raw;
        end
    end

    // A bad line reports zero in every field but the flag.
    assign ok           = !raw_reg.bad;
    assign rsp_valid    = valid_reg;
    assign bad_line     = raw_reg.bad;
    assign addr_len     = ok ? raw_reg.addr_len : '0;
    assign time_start   = ok ? raw_reg.time_start : '0;
    assign time_len     = ok ? raw_reg.time_len : '0;
    assign method_start = ok ? raw_reg.method_start : '0;
    assign method_len   = ok ? raw_reg.method_len : '0;
    assign path_start   = ok ? raw_reg.path_start : '0;
    assign path_len     = ok ? raw_reg.path_len : '0;

    // Negate a negative magnitude, clamp a positive one to the field's maximum.
    always_comb
    begin
        status = '0;
        size   = '0;
        if (ok)
        begin
            if (raw_reg.status_neg)
            begin
                status = $signed(alp_pkg::ST_W'(-raw_reg.status_acc));
            end
            else if (raw_reg.status_acc > alp_pkg::STATUS_MAX)
            begin
                status = $signed(alp_pkg::STATUS_MAX);
            end
            else
            begin
                status = $signed(raw_reg.status_acc);
            end
            if (raw_reg.size_neg)
            begin
                size = $signed(alp_pkg::SZ_W'(-raw_reg.size_acc));
            end
            else if (raw_reg.size_acc > alp_pkg::SIZE_MAX)
            begin
                size = $signed(alp_pkg::SIZE_MAX);
            end
            else
            begin
                size = $signed(raw_reg.size_acc);
            end
        end
    end

endmodule
